// ----- hdl/convex_polygon_span_table_assert.svh -----
// Assertion macros shared by the span table RTL.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef CONVEX_POLYGON_SPAN_TABLE_ASSERT_SVH
`define CONVEX_POLYGON_SPAN_TABLE_ASSERT_SVH

// Same-cycle implication.
`define CPST_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CPST_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/cpst_pkg.sv -----
// Types and constants for the convex polygon span table.
// No dependencies; used by convex_polygon_span_table, cpst_div and cpst_table.
`default_nettype none

package cpst_pkg;

  localparam int COORD_W  = 16;  // Q12.4 vertex coordinate
  localparam int COL_W    = 12;  // integer column
  localparam int Y_W      = 14;  // signed scanline index, covers -8192..8191
  localparam int ROW_IN_W = 10;  // row field of a read request
  localparam int SLOPE_W  = 32;  // Q16.16 slope
  localparam int ACC_W    = 40;  // Q24.16 edge accumulator
  localparam int FRAC_W   = 16;

  localparam logic signed [COL_W-1:0] COL_MAX = 12'sd2047;
  localparam logic signed [COL_W-1:0] COL_MIN = -12'sd2048;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_READ  = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EDGE,
    S_DIV,
    S_WALK,
    S_NEXT,
    S_CLEAR,
    S_READ,
    S_DONE
  } top_state_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_CLEAR,
    T_WALK
  } tbl_state_t;

  typedef struct packed {
    logic                      clr_go;
    logic                      walk_go;
    logic                      rd_go;
    logic [Y_W-1:0]            rd_row;
    logic signed [COORD_W-1:0] x1;
    logic signed [SLOPE_W-1:0] slope;
    logic signed [Y_W-1:0]     y_first;
    logic signed [Y_W-1:0]     y_last;
  } tbl_cmd_t;

  typedef struct packed {
    logic                    busy;
    logic                    rd_done;
    logic signed [COL_W-1:0] left;
    logic signed [COL_W-1:0] right;
  } tbl_stat_t;

endpackage

`default_nettype wire

// ----- hdl/cpst_in_if.sv -----
// Request channel: valid/ready plus one request item.
// Depends on nothing.
`default_nettype none

interface cpst_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [15:0] vertex_x;
  logic signed [15:0] vertex_y;
  logic               last_vertex;
  logic [9:0]         row;

  modport source (output valid, action, vertex_x, vertex_y, last_vertex, row,
                  input ready);
  modport sink   (input valid, action, vertex_x, vertex_y, last_vertex, row,
                  output ready);
endinterface

`default_nettype wire

// ----- hdl/cpst_out_if.sv -----
// Result channel: valid/ready plus one span item.
// Depends on nothing.
`default_nettype none

interface cpst_out_if;
  logic               valid;
  logic               ready;
  logic               span_valid;
  logic signed [11:0] span_left;
  logic signed [11:0] span_right;

  modport source (output valid, span_valid, span_left, span_right, input ready);
  modport sink   (input valid, span_valid, span_left, span_right, output ready);
endinterface

`default_nettype wire

// ----- hdl/convex_polygon_span_table.sv -----
// Channel    Dir  Handshake     Payload
// in_ch      in   valid/ready   action, vertex_x, vertex_y, last_vertex, row
// out_ch     out  valid/ready   span_valid, span_left, span_right
//
// One request at a time; exactly one result per request, held in an output
// register so the next request can enter while the result waits.
// Clear: the memory is swept, one row written per cycle.
// Add vertex: per non-horizontal edge, a slope divide and then a walk of its
// scanlines, one read-modify-write per row.
// Read row: through the registered memory port.
// After reset the table is swept to empty; in_ch.ready stays low meanwhile.
// Depends on cpst_pkg, cpst_in_if, cpst_out_if, cpst_div, cpst_table and convex_polygon_span_table_assert.svh.
`default_nettype none
`include "convex_polygon_span_table_assert.svh"

module convex_polygon_span_table #(
  parameter int ROWS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  cpst_in_if.sink     in_ch,
  cpst_out_if.source  out_ch
);

  localparam int XW = cpst_pkg::COORD_W;
  localparam int YW = cpst_pkg::Y_W;
  localparam int CW = cpst_pkg::COL_W;
  localparam int SW = cpst_pkg::SLOPE_W;
  localparam int RW = cpst_pkg::ROW_IN_W;
  localparam logic [YW-1:0] ROWS_U = YW'(ROWS);

  cpst_pkg::top_state_t state_r, state_nxt;

  logic signed [XW-1:0] first_x_r, first_x_nxt;
  logic signed [XW-1:0] first_y_r, first_y_nxt;
  logic signed [XW-1:0] prior_x_r, prior_x_nxt;
  logic signed [XW-1:0] prior_y_r, prior_y_nxt;
  logic                 has_vertex_r, has_vertex_nxt;
  logic                 close_pend_r, close_pend_nxt;
  logic signed [XW-1:0] e_ax_r, e_ax_nxt;
  logic signed [XW-1:0] e_ay_r, e_ay_nxt;
  logic signed [XW-1:0] e_bx_r, e_bx_nxt;
  logic signed [XW-1:0] e_by_r, e_by_nxt;
  logic signed [XW-1:0] x1_r, x1_nxt;
  logic signed [YW-1:0] yf_r, yf_nxt;
  logic signed [YW-1:0] yl_r, yl_nxt;
  logic                 res_sv_r, res_sv_nxt;
  logic signed [CW-1:0] res_l_r, res_l_nxt;
  logic signed [CW-1:0] res_r_r, res_r_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_sv_r, out_sv_nxt;
  logic signed [CW-1:0] out_l_r, out_l_nxt;
  logic signed [CW-1:0] out_r_r, out_r_nxt;

  logic                 accept;
  logic                 row_ok;
  logic                 out_load;
  logic                 swap;
  logic signed [XW-1:0] ox1, oy1, ox2, oy2;
  logic signed [XW:0]   dx, dy, dx_abs, y1_up;
  logic                 div_start;
  logic                 div_done;
  logic signed [SW-1:0] div_quot;

  cpst_pkg::tbl_cmd_t   tbl_cmd;
  cpst_pkg::tbl_stat_t  tbl_stat;

  assign in_ch.ready = (state_r == cpst_pkg::S_IDLE) && !tbl_stat.busy;
  assign accept      = in_ch.valid && in_ch.ready;
  assign row_ok      = {{(YW-RW){1'b0}}, in_ch.row} < ROWS_U;
  assign out_load    = (state_r == cpst_pkg::S_DONE) && (!out_valid_r || out_ch.ready);

  // edge ordered top to bottom, its slope terms and row range
  always_comb begin
    swap   = e_ay_r > e_by_r;
    ox1    = swap ? e_bx_r : e_ax_r;
    oy1    = swap ? e_by_r : e_ay_r;
    ox2    = swap ? e_ax_r : e_bx_r;
    oy2    = swap ? e_ay_r : e_by_r;
    dx     = $signed({ox2[XW-1], ox2}) - $signed({ox1[XW-1], ox1});
    dy     = $signed({oy2[XW-1], oy2}) - $signed({oy1[XW-1], oy1});
    dx_abs = dx[XW] ? -dx : dx;
    y1_up  = $signed({oy1[XW-1], oy1}) + 17'sd15;
  end

  assign div_start = (state_r == cpst_pkg::S_EDGE) && (e_ay_r != e_by_r);

  cpst_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .neg   (dx[XW]),
    .mag   (dx_abs[XW-1:0]),
    .den   (dy[XW-1:0]),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    tbl_cmd.clr_go  = accept && (in_ch.action == cpst_pkg::ACT_CLEAR);
    tbl_cmd.rd_go   = accept && (in_ch.action == cpst_pkg::ACT_READ) && row_ok;
    tbl_cmd.rd_row  = {{(YW-RW){1'b0}}, in_ch.row};
    tbl_cmd.walk_go = (state_r == cpst_pkg::S_DIV) && div_done;
    tbl_cmd.x1      = x1_r;
    tbl_cmd.slope   = div_quot;
    tbl_cmd.y_first = yf_r;
    tbl_cmd.y_last  = yl_r;
  end

  cpst_table #(
    .ROWS (ROWS)
  ) u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (tbl_cmd),
    .stat  (tbl_stat)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cpst_pkg::S_IDLE: begin
        if (accept) begin
          case (in_ch.action)
            cpst_pkg::ACT_CLEAR: state_nxt = cpst_pkg::S_CLEAR;
            cpst_pkg::ACT_ADD:
              state_nxt = has_vertex_r ? cpst_pkg::S_EDGE : cpst_pkg::S_NEXT;
            cpst_pkg::ACT_READ:
              state_nxt = row_ok ? cpst_pkg::S_READ : cpst_pkg::S_DONE;
            default: state_nxt = cpst_pkg::S_DONE;
          endcase
        end
      end
      cpst_pkg::S_EDGE: begin
        state_nxt = (e_ay_r == e_by_r) ? cpst_pkg::S_NEXT : cpst_pkg::S_DIV;
      end
      cpst_pkg::S_DIV: begin
        if (div_done) begin
          state_nxt = cpst_pkg::S_WALK;
        end
      end
      cpst_pkg::S_WALK: begin
        if (!tbl_stat.busy) begin
          state_nxt = cpst_pkg::S_NEXT;
        end
      end
      cpst_pkg::S_NEXT: begin
        state_nxt = close_pend_r ? cpst_pkg::S_EDGE : cpst_pkg::S_DONE;
      end
      cpst_pkg::S_CLEAR: begin
        if (!tbl_stat.busy) begin
          state_nxt = cpst_pkg::S_DONE;
        end
      end
      cpst_pkg::S_READ: begin
        if (tbl_stat.rd_done) begin
          state_nxt = cpst_pkg::S_DONE;
        end
      end
      cpst_pkg::S_DONE: begin
        if (out_load) begin
          state_nxt = cpst_pkg::S_IDLE;
        end
      end
      default: state_nxt = cpst_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    first_x_nxt    = first_x_r;
    first_y_nxt    = first_y_r;
    prior_x_nxt    = prior_x_r;
    prior_y_nxt    = prior_y_r;
    has_vertex_nxt = has_vertex_r;
    close_pend_nxt = close_pend_r;
    e_ax_nxt       = e_ax_r;
    e_ay_nxt       = e_ay_r;
    e_bx_nxt       = e_bx_r;
    e_by_nxt       = e_by_r;
    x1_nxt         = x1_r;
    yf_nxt         = yf_r;
    yl_nxt         = yl_r;
    res_sv_nxt     = res_sv_r;
    res_l_nxt      = res_l_r;
    res_r_nxt      = res_r_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_sv_nxt     = out_sv_r;
    out_l_nxt      = out_l_r;
    out_r_nxt      = out_r_r;
    case (state_r)
      cpst_pkg::S_IDLE: begin
        if (accept) begin
          res_sv_nxt = 1'b0;
          res_l_nxt  = '0;
          res_r_nxt  = '0;
          if (in_ch.action == cpst_pkg::ACT_ADD) begin
            if (has_vertex_r) begin
              e_ax_nxt = prior_x_r;
              e_ay_nxt = prior_y_r;
              e_bx_nxt = in_ch.vertex_x;
              e_by_nxt = in_ch.vertex_y;
            end else begin
              first_x_nxt = in_ch.vertex_x;
              first_y_nxt = in_ch.vertex_y;
            end
            prior_x_nxt    = in_ch.vertex_x;
            prior_y_nxt    = in_ch.vertex_y;
            has_vertex_nxt = !in_ch.last_vertex;
            close_pend_nxt = in_ch.last_vertex;
          end
        end
      end
      cpst_pkg::S_EDGE: begin
        x1_nxt = ox1;
        yf_nxt = $signed({y1_up[XW], y1_up[XW:4]});
        yl_nxt = $signed({{(YW-XW+4){oy2[XW-1]}}, oy2[XW-1:4]});
      end
      cpst_pkg::S_NEXT: begin
        // closing edge from the last vertex back to the first
        if (close_pend_r) begin
          e_ax_nxt       = prior_x_r;
          e_ay_nxt       = prior_y_r;
          e_bx_nxt       = first_x_r;
          e_by_nxt       = first_y_r;
          close_pend_nxt = 1'b0;
        end
      end
      cpst_pkg::S_READ: begin
        if (tbl_stat.rd_done) begin
          res_sv_nxt = tbl_stat.left <= tbl_stat.right;
          res_l_nxt  = tbl_stat.left;
          res_r_nxt  = tbl_stat.right;
        end
      end
      cpst_pkg::S_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_sv_nxt    = res_sv_r;
          out_l_nxt     = res_l_r;
          out_r_nxt     = res_r_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= cpst_pkg::S_IDLE;
      first_x_r    <= '0;
      first_y_r    <= '0;
      prior_x_r    <= '0;
      prior_y_r    <= '0;
      has_vertex_r <= 1'b0;
      close_pend_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      first_x_r    <= first_x_nxt;
      first_y_r    <= first_y_nxt;
      prior_x_r    <= prior_x_nxt;
      prior_y_r    <= prior_y_nxt;
      has_vertex_r <= has_vertex_nxt;
      close_pend_r <= close_pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    e_ax_r   <= e_ax_nxt;
    e_ay_r   <= e_ay_nxt;
    e_bx_r   <= e_bx_nxt;
    e_by_r   <= e_by_nxt;
    x1_r     <= x1_nxt;
    yf_r     <= yf_nxt;
    yl_r     <= yl_nxt;
    res_sv_r <= res_sv_nxt;
    res_l_r  <= res_l_nxt;
    res_r_r  <= res_r_nxt;
    out_sv_r <= out_sv_nxt;
    out_l_r  <= out_l_nxt;
    out_r_r  <= out_r_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.span_valid = out_sv_r;
  assign out_ch.span_left  = out_l_r;
  assign out_ch.span_right = out_r_r;

  `CPST_ASSERT_IMP(a_div_done_in_div, div_done, state_r == cpst_pkg::S_DIV, "slope ready outside divide state")
  `CPST_ASSERT_IMP(a_close_after_last, close_pend_r, !has_vertex_r, "closing edge pending with open polygon")
  `CPST_ASSERT_NXT(a_read_one_cycle, state_r == cpst_pkg::S_READ, state_r == cpst_pkg::S_DONE, "row read data late")

endmodule

`default_nettype wire

// ----- hdl/cpst_div.sv -----
// Restoring divider for the edge slope: (|dx| << 16) / dy, one bit per cycle,
// signed and saturated to 32 bits. Depends on cpst_pkg.
`default_nettype none

module cpst_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                neg,
  input  logic [cpst_pkg::COORD_W-1:0]        mag,
  input  logic [cpst_pkg::COORD_W-1:0]        den,
  output logic                                done,
  output logic signed [cpst_pkg::SLOPE_W-1:0] quot
);

  localparam int NW = cpst_pkg::SLOPE_W;
  localparam int DW = cpst_pkg::COORD_W;
  localparam int CW = $clog2(NW);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] num_r, num_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic          neg_r, neg_nxt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic [NW-1:0] neg_q;

  always_comb begin
    trial    = {rem_r, num_r[NW-1]};
    diff     = trial - {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = {mag, {(NW-DW){1'b0}}};
      rem_nxt  = '0;
      den_nxt  = den;
      neg_nxt  = neg;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = diff[DW-1:0];
        num_nxt = {num_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DW-1:0];
        num_nxt = {num_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(NW-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Sign and clamp to the signed 32-bit range.
  always_comb begin
    neg_q = '0 - num_r;
    if (neg_r) begin
      if (num_r > {1'b1, {(NW-1){1'b0}}}) begin
        quot = $signed({1'b1, {(NW-1){1'b0}}});
      end else begin
        quot = $signed(neg_q);
      end
    end else if (num_r[NW-1]) begin
      quot = $signed({1'b0, {(NW-1){1'b1}}});
    end else begin
      quot = $signed(num_r);
    end
  end

  assign done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

endmodule

`default_nettype wire

// ----- hdl/cpst_table.sv -----
// Span memory with its clear sweep, edge row walk, read-modify-write stage and row read.
// Depends on cpst_pkg and convex_polygon_span_table_assert.svh.
`default_nettype none
`include "convex_polygon_span_table_assert.svh"

module cpst_table #(
  parameter int ROWS = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cpst_pkg::tbl_cmd_t  cmd,
  output cpst_pkg::tbl_stat_t stat
);

  localparam int AW    = $clog2(ROWS);
  localparam int CW    = cpst_pkg::COL_W;
  localparam int MW    = 2 * CW;
  localparam int YW    = cpst_pkg::Y_W;
  localparam int ACCW  = cpst_pkg::ACC_W;
  localparam int FW    = cpst_pkg::FRAC_W;
  localparam int SW    = cpst_pkg::SLOPE_W;
  localparam int XW    = cpst_pkg::COORD_W;
  localparam int IW    = ACCW - FW;
  localparam int XSH   = FW - 4;  // Q12.4 to Q24.16
  localparam logic signed [YW-1:0] ROWS_Y = YW'(ROWS);
  localparam logic [AW-1:0]        LAST_A = AW'(ROWS - 1);
  localparam logic signed [IW-1:0] HI_I   =
    $signed({{(IW-CW){cpst_pkg::COL_MAX[CW-1]}}, cpst_pkg::COL_MAX});
  localparam logic signed [IW-1:0] LO_I   =
    $signed({{(IW-CW){cpst_pkg::COL_MIN[CW-1]}}, cpst_pkg::COL_MIN});

  logic [MW-1:0] mem [ROWS];

  cpst_pkg::tbl_state_t    state_r, state_nxt;
  logic [AW-1:0]           clr_addr_r, clr_addr_nxt;
  logic signed [YW-1:0]    y_r, y_nxt;
  logic signed [YW-1:0]    y_last_r, y_last_nxt;
  logic signed [ACCW-1:0]  acc_r, acc_nxt;
  logic signed [SW-1:0]    slope_r, slope_nxt;
  logic                    wb_v_r, wb_v_nxt;
  logic [AW-1:0]           wb_addr_r, wb_addr_nxt;
  logic signed [CW-1:0]    wb_col_r, wb_col_nxt;
  logic                    rd_done_r, rd_done_nxt;
  logic [MW-1:0]           rd_data_r;

  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic [MW-1:0]           wr_data;
  logic                    walk_live;
  logic signed [IW-1:0]    ceil_i;
  logic signed [CW-1:0]    col;
  logic signed [CW-1:0]    old_l;
  logic signed [CW-1:0]    old_r;
  logic signed [CW-1:0]    new_l;
  logic signed [CW-1:0]    new_r;

  assign walk_live = (y_r <= y_last_r) && (y_r < ROWS_Y);

  // ceil(acc) in whole pixels, clamped to the column range
  always_comb begin
    ceil_i = $signed(acc_r[ACCW-1:FW]) +
             $signed({{(IW-1){1'b0}}, |acc_r[FW-1:0]});
    if (ceil_i > HI_I) begin
      col = cpst_pkg::COL_MAX;
    end else if (ceil_i < LO_I) begin
      col = cpst_pkg::COL_MIN;
    end else begin
      col = ceil_i[CW-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cpst_pkg::T_IDLE: begin
        if (cmd.clr_go) begin
          state_nxt = cpst_pkg::T_CLEAR;
        end else if (cmd.walk_go) begin
          state_nxt = cpst_pkg::T_WALK;
        end
      end
      cpst_pkg::T_CLEAR: begin
        if (clr_addr_r == LAST_A) begin
          state_nxt = cpst_pkg::T_IDLE;
        end
      end
      cpst_pkg::T_WALK: begin
        if (!walk_live) begin
          state_nxt = cpst_pkg::T_IDLE;
        end
      end
      default: state_nxt = cpst_pkg::T_IDLE;
    endcase
  end

  always_comb begin
    clr_addr_nxt = clr_addr_r;
    y_nxt        = y_r;
    y_last_nxt   = y_last_r;
    acc_nxt      = acc_r;
    slope_nxt    = slope_r;
    wb_v_nxt     = 1'b0;
    wb_addr_nxt  = wb_addr_r;
    wb_col_nxt   = wb_col_r;
    rd_done_nxt  = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = wb_addr_r;
    case (state_r)
      cpst_pkg::T_IDLE: begin
        if (cmd.clr_go) begin
          clr_addr_nxt = '0;
        end
        if (cmd.walk_go) begin
          y_nxt      = cmd.y_first;
          y_last_nxt = cmd.y_last;
          acc_nxt    = $signed({{(ACCW-XW-XSH){cmd.x1[XW-1]}}, cmd.x1, {XSH{1'b0}}});
          slope_nxt  = cmd.slope;
        end
        if (cmd.rd_go) begin
          rd_en       = 1'b1;
          rd_addr     = cmd.rd_row[AW-1:0];
          rd_done_nxt = 1'b1;
        end
      end
      cpst_pkg::T_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
      cpst_pkg::T_WALK: begin
        if (walk_live) begin
          y_nxt   = y_r + 1'b1;
          acc_nxt = acc_r + $signed({{(ACCW-SW){slope_r[SW-1]}}, slope_r});
          // rows above the table still advance x
          if (!y_r[YW-1]) begin
            rd_en       = 1'b1;
            rd_addr     = y_r[AW-1:0];
            wb_v_nxt    = 1'b1;
            wb_addr_nxt = y_r[AW-1:0];
            wb_col_nxt  = col;
          end
        end
      end
      default: ;
    endcase
  end

  // write side: clear sweep or the second half of a row update
  always_comb begin
    old_l   = rd_data_r[MW-1:CW];
    old_r   = rd_data_r[CW-1:0];
    new_l   = (wb_col_r < old_l) ? wb_col_r : old_l;
    new_r   = (wb_col_r > old_r) ? wb_col_r : old_r;
    wr_en   = 1'b0;
    wr_addr = wb_addr_r;
    wr_data = {new_l, new_r};
    if (state_r == cpst_pkg::T_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
      wr_data = {cpst_pkg::COL_MAX, cpst_pkg::COL_MIN};
    end else if (wb_v_r) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= cpst_pkg::T_CLEAR;
      clr_addr_r <= '0;
      wb_v_r     <= 1'b0;
      rd_done_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      wb_v_r     <= wb_v_nxt;
      rd_done_r  <= rd_done_nxt;
    end
    y_r       <= y_nxt;
    y_last_r  <= y_last_nxt;
    acc_r     <= acc_nxt;
    slope_r   <= slope_nxt;
    wb_addr_r <= wb_addr_nxt;
    wb_col_r  <= wb_col_nxt;
  end

  assign stat.busy    = (state_r != cpst_pkg::T_IDLE) || wb_v_r;
  assign stat.rd_done = rd_done_r;
  assign stat.left    = rd_data_r[MW-1:CW];
  assign stat.right   = rd_data_r[CW-1:0];

  `CPST_ASSERT_IMP(a_rmw_no_collide, wb_v_r && rd_en, rd_addr != wb_addr_r, "row read hits pending write-back")
  `CPST_ASSERT_IMP(a_clear_no_wb, state_r == cpst_pkg::T_CLEAR, !wb_v_r, "write-back during clear sweep")
  `CPST_ASSERT_IMP(a_cmd_when_idle, cmd.clr_go || cmd.walk_go || cmd.rd_go, state_r == cpst_pkg::T_IDLE && !wb_v_r, "command while table busy")

endmodule

`default_nettype wire
